/* rtl/core/trpm_pkg.sv */
// shared types and constants of the tachometer led bar driver
// no dependencies; imported by every module of the block
package trpm_pkg;

    localparam int CNT_W   = 16;
    localparam int DIV_W   = 24;
    localparam int QDEPTH  = 2;

    localparam logic [7:0] HDR_START = 8'd0;
    localparam logic [7:0] HDR_BLANK = 8'd224;
    localparam logic [7:0] COL_FULL  = 8'd255;
    localparam logic [7:0] COL_OFF   = 8'd0;

    typedef struct packed {
        logic [4:0]       brightness;
        logic [DIV_W-1:0] count_scale;
        logic [15:0]      full_scale_rpm;
        logic [4:0]       green_leds;
        logic [4:0]       yellow_leds;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             flash;
    } t_job;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/core/trpm_front.sv */
// front end: accepts input words, keeps the flash phase, queues captures
// depends on trpm_pkg
module trpm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [15:0]           i_s_tdata,   // capture_count
    input  logic                  i_s_tuser,   // cmd
    input  logic                  i_q_full,
    output logic                  o_push,
    output trpm_pkg::t_job        o_job
);
    import trpm_pkg::*;

    logic r_flash;
    logic accept;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_push     = accept && !i_s_tuser;
    assign o_job      = '{count: i_s_tdata, flash: r_flash};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash <= 1'b0;
        end else if (accept && i_s_tuser) begin
            r_flash <= !r_flash;
        end
    end

endmodule

/* rtl/core/trpm_queue.sv */
// short job queue between front and back ends
// depends on trpm_pkg
module trpm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  trpm_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output trpm_pkg::t_job o_job
);
    import trpm_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/trpm_div.sv */
// restoring divider, one quotient bit per cycle
// depends on trpm_pkg
module trpm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [trpm_pkg::DIV_W-1:0] i_dividend,
    input  logic [15:0]                i_divisor,
    output trpm_pkg::t_div_stat        o_stat,
    output logic [trpm_pkg::DIV_W-1:0] o_quot
);
    import trpm_pkg::*;

    localparam int SW = $clog2(DIV_W);

    logic [15:0]      r_rem;
    logic [15:0]      r_div;
    logic [DIV_W-1:0] r_quot;
    logic [SW-1:0]    r_step;
    logic             r_busy;
    logic             r_done;
    logic [16:0]      sh;
    logic             ge;
    logic [16:0]      diff;

    assign sh   = {r_rem, r_quot[DIV_W-1]};
    assign ge   = (sh >= {1'b0, r_div});
    assign diff = sh - {1'b0, r_div};

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[15:0] : sh[15:0];
            r_quot <= {r_quot[DIV_W-2:0], ge};
        end
    end

endmodule

/* rtl/core/trpm_back.sv */
// back end: rpm and lit count through the divider, then the frame sequencer
// depends on trpm_pkg and trpm_div
module trpm_back #(
    parameter int LED_COUNT = 30
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  trpm_pkg::t_cfg i_cfg,
    input  logic           i_job_valid,
    input  trpm_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [31:0]    o_m_tdata,   // frame_header, frame_blue, frame_green, frame_red
    output logic           o_m_tlast    // last_frame
);
    import trpm_pkg::*;

    localparam int IW = $clog2(LED_COUNT + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV1 = 2'd1;
    localparam logic [1:0] S_DIV2 = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [IW:0] LEN_RUN = (IW + 1)'(LED_COUNT + 2);
    localparam logic [IW:0] LEN_RED = (IW + 1)'(LED_COUNT + 1);

    logic [1:0]       r_state;
    logic             r_flash;
    logic             r_shift;
    logic [IW-1:0]    r_lit;
    logic             r_seg;
    logic [IW-1:0]    r_idx;
    logic             r_out_valid;
    logic [31:0]      r_out_data;
    logic             r_out_last;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [15:0]      div_divisor;
    t_div_stat        div_stat;
    logic [DIV_W-1:0] div_quot;

    logic [15:0]      fs;
    logic [15:0]      rpm;
    logic [IW:0]      seg_len;
    logic             idx_last;
    logic             slot_free;
    logic             emit_load;
    logic [6:0]       led_i;
    logic [6:0]       zone_g;
    logic [6:0]       zone_y;
    logic [7:0]       lit_hdr;
    logic [7:0]       n_hdr;
    logic [7:0]       n_blue;
    logic [7:0]       n_green;
    logic [7:0]       n_red;
    logic             n_last;

    trpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    assign fs  = (i_cfg.full_scale_rpm == '0) ? 16'd1 : i_cfg.full_scale_rpm;
    assign rpm = (div_quot[DIV_W-1:16] != '0) ? 16'hFFFF : div_quot[15:0];

    assign o_pop = (r_state == S_IDLE) && i_job_valid;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = fs;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    div_start = 1'b1;
                    if (i_job.count != '0) begin
                        div_dividend = i_cfg.count_scale;
                        div_divisor  = i_job.count;
                    end
                end
            end
            S_DIV1: begin
                if (div_stat.done) begin
                    div_start    = 1'b1;
                    div_dividend = {{(DIV_W - 16){1'b0}}, rpm} * DIV_W'(LED_COUNT);
                end
            end
            default: begin
            end
        endcase
    end

    // frame contents for the current sequence position
    always_comb begin
        if (!r_seg || (r_shift && !r_flash)) begin
            seg_len = LEN_RUN;
        end else if (r_shift) begin
            seg_len = LEN_RED;
        end else begin
            seg_len = {1'b0, r_lit} + 1'b1;
        end
        idx_last = ({1'b0, r_idx} == seg_len - 1'b1);
        n_last   = r_seg && idx_last;

        lit_hdr = HDR_BLANK + {3'b0, i_cfg.brightness};
        led_i   = 7'(r_idx) - 7'd1;
        zone_g  = {2'b0, i_cfg.green_leds};
        zone_y  = {2'b0, i_cfg.green_leds} + {2'b0, i_cfg.yellow_leds};

        n_blue  = COL_OFF;
        n_green = COL_OFF;
        n_red   = COL_OFF;
        if (r_idx == '0) begin
            n_hdr = HDR_START;
        end else if (!r_seg || (r_shift && !r_flash)) begin
            n_hdr = HDR_BLANK;
        end else if (r_shift) begin
            n_hdr = lit_hdr;
            n_red = COL_FULL;
        end else begin
            n_hdr = lit_hdr;
            if (led_i < zone_g) begin
                n_green = COL_FULL;
            end else if (led_i < zone_y) begin
                n_green = COL_FULL;
                n_red   = COL_FULL;
            end else begin
                n_red   = COL_FULL;
            end
        end
    end

    assign slot_free = !r_out_valid || i_m_tready;
    assign emit_load = (r_state == S_EMIT) && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_seg       <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_out_valid <= emit_load || (r_out_valid && !i_m_tready);
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_flash <= i_job.flash;
                        r_state <= (i_job.count != '0) ? S_DIV1 : S_DIV2;
                    end
                end
                S_DIV1: begin
                    if (div_stat.done) begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_stat.done) begin
                        r_shift <= (div_quot > DIV_W'(LED_COUNT));
                        r_lit   <= div_quot[IW-1:0];
                        r_seg   <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_data  <= {n_red, n_green, n_blue, n_hdr};
                        r_out_last  <= n_last;
                        if (n_last) begin
                            r_state <= S_IDLE;
                        end else if (idx_last) begin
                            r_seg <= 1'b1;
                            r_idx <= '0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_emit_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !div_stat.busy)
        else $error("divider running during frame output");

    a_lit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_shift) |-> ({1'b0, r_lit} <= (IW + 1)'(LED_COUNT)))
        else $error("lit count beyond strip in metered tail");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && slot_free && n_last) |=> (r_state == S_IDLE))
        else $error("sequencer did not finish after last word");

endmodule

/* rtl/core/tach_rpm_led_bar_driver_unit.sv */
// top level of the tachometer shift-light led bar driver: config registers,
// front end, job queue and back end; depends on trpm_pkg and all trpm_ modules
//
// channel   dir  handshake             payload
// s         in   i_s_tvalid/o_s_tready tdata capture_count, tuser cmd
// m         out  o_m_tvalid/i_m_tready tdata header,blue,green,red, tlast last_frame
// cfg       in   i_cfg_we              i_cfg_idx, i_cfg_data
//
// a capture is dequeued, then runs two divider passes of 24 steps each, each ending in a done strobe
// (one pass when the count is zero), then one frame word per cycle unless i_m_tready stalls,
// LED_COUNT+3 to 2*LED_COUNT+4 frames; the divider is serial, the output register holds one word
// ticks produce no words; up to two captures queue ahead
// reset is synchronous, active low; no clearing pass
module tach_rpm_led_bar_driver_unit #(
    parameter int LED_COUNT = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // capture_count
    input  logic        i_s_tuser,   // cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // frame_header, frame_blue, frame_green, frame_red
    output logic        o_m_tlast,   // last_frame
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    import trpm_pkg::*;

    localparam logic [2:0] REG_BRIGHT = 3'd0;
    localparam logic [2:0] REG_SCALE  = 3'd1;
    localparam logic [2:0] REG_FULL   = 3'd2;
    localparam logic [2:0] REG_GREEN  = 3'd3;
    localparam logic [2:0] REG_YELLOW = 3'd4;

    t_cfg r_cfg;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job q_in;
    t_job q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness     <= 5'd3;
            r_cfg.count_scale    <= 24'd5625000;
            r_cfg.full_scale_rpm <= 16'd10500;
            r_cfg.green_leds     <= 5'd18;
            r_cfg.yellow_leds    <= 5'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BRIGHT: r_cfg.brightness     <= i_cfg_data[4:0];
                REG_SCALE:  r_cfg.count_scale    <= i_cfg_data;
                REG_FULL:   r_cfg.full_scale_rpm <= i_cfg_data[15:0];
                REG_GREEN:  r_cfg.green_leds     <= i_cfg_data[4:0];
                REG_YELLOW: r_cfg.yellow_leds    <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    trpm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (q_in)
    );

    trpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_out)
    );

    trpm_back #(
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (q_valid),
        .i_job       (q_out),
        .o_pop       (q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
